// ===== design/gsp_pkg.sv =====
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared widths, operation and status codes, and the request and result
// structures of the generational slot pool.
// ----------------------------------------------------------------------------
package gsp_pkg;

   // Default storage shape
   localparam int SLOT_COUNT_DEF = 16;
   localparam int KEY_BITS_DEF   = 16;
   localparam int GEN_BITS_DEF   = 16;

   // Field widths on the ports
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 4;
   localparam int KEY_W    = 16;
   localparam int GEN_W    = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int REV_W    = 16;
   localparam int LIMIT_W  = 5;

   // Stream bus widths, padded to whole bytes
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;

   // Slot limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FIND    = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ACTIVE = 2'd3;

   // One request as the sequencer takes it
   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [INDEX_W-1:0] index;
      logic [KEY_W-1:0]   key;
   } cmd_type;

   // One result; the last member sits in the lowest bits of rsp_tdata
   typedef struct packed {
      logic [REV_W-1:0]    rev;
      logic [COUNT_W-1:0]  span;
      logic [COUNT_W-1:0]  live;
      logic [STATUS_W-1:0] status;
      logic [GEN_W-1:0]    gen;
      logic [INDEX_W-1:0]  slot;
   } result_type;

endpackage

// ===== design/gsp_ram.sv =====
// ----------------------------------------------------------------------------
// gsp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/gsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsp_ctrl
// Slot pool sequencer: scans active marks and the key/generation RAMs one
// slot per cycle, and runs reserve, release and find on the pool state.
// ----------------------------------------------------------------------------
module gsp_ctrl #(
   parameter int SLOT_COUNT      = gsp_pkg::SLOT_COUNT_DEF,
   parameter int KEY_BITS        = gsp_pkg::KEY_BITS_DEF,
   parameter int GENERATION_BITS = gsp_pkg::GEN_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  gsp_pkg::cmd_type             cmd,
   input  logic [gsp_pkg::LIMIT_W-1:0]  limit,
   input  logic                         result_take,
   output logic                         idle,
   output logic                         result_valid,
   output gsp_pkg::result_type          result
);

   localparam int IW = $clog2(SLOT_COUNT);
   localparam int CW = $clog2(SLOT_COUNT + 1);
   localparam int XW = (CW > gsp_pkg::LIMIT_W) ? CW : gsp_pkg::LIMIT_W;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_RSV_SCAN   = 4'd1;
   localparam logic [3:0] ST_RSV_READ   = 4'd2;
   localparam logic [3:0] ST_RSV_WRITE  = 4'd3;
   localparam logic [3:0] ST_RLS_CHECK  = 4'd4;
   localparam logic [3:0] ST_RLS_GEN    = 4'd5;
   localparam logic [3:0] ST_RLS_SHRINK = 4'd6;
   localparam logic [3:0] ST_FIND       = 4'd7;
   localparam logic [3:0] ST_FINISH     = 4'd8;

   logic [3:0]                     state_ff, state_in;
   gsp_pkg::cmd_type               cmd_ff, cmd_in;
   logic [CW-1:0]                  scan_ff, scan_in;
   logic [IW-1:0]                  pick_ff, pick_in;
   logic                           append_ff, append_in;
   logic                           pend_ff, pend_in;
   logic [IW-1:0]                  prev_ff, prev_in;
   logic                           shrink_ff, shrink_in;
   logic [SLOT_COUNT-1:0]          active_ff, active_in;
   logic [SLOT_COUNT-1:0]          touched_ff, touched_in;
   logic [CW-1:0]                  total_ff, total_in;
   logic [CW-1:0]                  span_ff, span_in;
   logic [gsp_pkg::REV_W-1:0]      rev_ff, rev_in;
   logic [gsp_pkg::INDEX_W-1:0]    res_slot_ff, res_slot_in;
   logic [gsp_pkg::GEN_W-1:0]      res_gen_ff, res_gen_in;
   logic [gsp_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;

   logic                           ram_rd_en;
   logic [IW-1:0]                  ram_rd_addr;
   logic                           ram_wr_en;
   logic [KEY_BITS-1:0]            key_rd;
   logic [GENERATION_BITS-1:0]     gen_rd;

   logic [KEY_BITS-1:0]            key_cut;
   logic [IW-1:0]                  scan_idx;
   logic [CW-1:0]                  span_dec;
   logic [IW-1:0]                  span_dec_idx;
   logic [IW-1:0]                  idx_addr;
   logic                           in_pool;
   logic                           pool_full;
   logic [GENERATION_BITS-1:0]     gen_old;
   logic [GENERATION_BITS-1:0]     gen_inc;
   logic [GENERATION_BITS-1:0]     gen_new;
   logic                           key_hit;

   // Keys and generations live in RAM, read one slot per cycle
   gsp_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (SLOT_COUNT)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pick_ff),
      .wr_data (key_cut),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (key_rd)
   );

   gsp_ram #(
      .WIDTH (GENERATION_BITS),
      .DEPTH (SLOT_COUNT)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pick_ff),
      .wr_data (gen_new),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (gen_rd)
   );

   // Shared compare and increment datapath
   always_comb begin
      key_cut      = KEY_BITS'(cmd_ff.key);
      scan_idx     = scan_ff[IW-1:0];
      span_dec     = span_ff - 1'b1;
      span_dec_idx = span_dec[IW-1:0];
      idx_addr     = IW'(cmd_ff.index);
      in_pool      = XW'(cmd_ff.index) < XW'(SLOT_COUNT);
      pool_full    = (XW'(span_ff) >= XW'(limit)) || (span_ff == CW'(SLOT_COUNT));
      // A generation never written reads as zero
      gen_old      = touched_ff[pick_ff] ? gen_rd : '0;
      gen_inc      = gen_old + 1'b1;
      gen_new      = (gen_inc == '0) ? GENERATION_BITS'(1) : gen_inc;
      key_hit      = pend_ff && active_ff[prev_ff] && (key_rd == key_cut);
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      scan_in       = scan_ff;
      pick_in       = pick_ff;
      append_in     = append_ff;
      pend_in       = pend_ff;
      prev_in       = prev_ff;
      shrink_in     = shrink_ff;
      active_in     = active_ff;
      touched_in    = touched_ff;
      total_in      = total_ff;
      span_in       = span_ff;
      rev_in        = rev_ff;
      res_slot_in   = res_slot_ff;
      res_gen_in    = res_gen_ff;
      res_status_in = res_status_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = pick_ff;
      ram_wr_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in        = cmd;
               scan_in       = '0;
               pend_in       = 1'b0;
               shrink_in     = 1'b0;
               append_in     = 1'b0;
               res_slot_in   = '0;
               res_gen_in    = '0;
               res_status_in = gsp_pkg::STATUS_OK;
               case (cmd.mode)
                  gsp_pkg::MODE_RESERVE: state_in = ST_RSV_SCAN;
                  gsp_pkg::MODE_RELEASE: state_in = ST_RLS_CHECK;
                  gsp_pkg::MODE_FIND:    state_in = ST_FIND;
                  default:               state_in = ST_FINISH;
               endcase
            end
         end

         // Look for the first hole below the span, else append, or report full at the limit
         ST_RSV_SCAN: begin
            if (scan_ff < span_ff) begin
               if (!active_ff[scan_idx]) begin
                  pick_in  = scan_idx;
                  state_in = ST_RSV_READ;
               end else begin
                  scan_in = scan_ff + 1'b1;
               end
            end else if (pool_full) begin
               res_status_in = gsp_pkg::STATUS_FULL;
               state_in      = ST_FINISH;
            end else begin
               pick_in   = span_ff[IW-1:0];
               append_in = 1'b1;
               state_in  = ST_RSV_READ;
            end
         end

         ST_RSV_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = pick_ff;
            state_in    = ST_RSV_WRITE;
         end

         // Bump generation, store key, mark active
         ST_RSV_WRITE: begin
            ram_wr_en           = 1'b1;
            active_in[pick_ff]  = 1'b1;
            touched_in[pick_ff] = 1'b1;
            total_in            = total_ff + 1'b1;
            if (append_ff) begin
               span_in = span_ff + 1'b1;
            end
            rev_in        = rev_ff + 1'b1;
            res_slot_in   = gsp_pkg::INDEX_W'(pick_ff);
            res_gen_in    = gsp_pkg::GEN_W'(gen_new);
            res_status_in = gsp_pkg::STATUS_OK;
            state_in      = ST_FINISH;
         end

         ST_RLS_CHECK: begin
            res_slot_in = cmd_ff.index;
            if (!in_pool) begin
               res_gen_in    = '0;
               res_status_in = gsp_pkg::STATUS_NOT_ACTIVE;
               state_in      = ST_FINISH;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_addr;
               pick_in     = idx_addr;
               if (active_ff[idx_addr]) begin
                  active_in[idx_addr] = 1'b0;
                  total_in            = total_ff - 1'b1;
                  rev_in              = rev_ff + 1'b1;
                  shrink_in = (XW'(cmd_ff.index) + 1'b1) == XW'(span_ff);
                  res_status_in       = gsp_pkg::STATUS_OK;
               end else begin
                  res_status_in = gsp_pkg::STATUS_NOT_ACTIVE;
               end
               state_in = ST_RLS_GEN;
            end
         end

         ST_RLS_GEN: begin
            res_gen_in = gsp_pkg::GEN_W'(gen_old);
            state_in   = shrink_ff ? ST_RLS_SHRINK : ST_FINISH;
         end

         // Drop trailing inactive slots off the span
         ST_RLS_SHRINK: begin
            if ((span_ff != '0) && !active_ff[span_dec_idx]) begin
               span_in = span_dec;
            end else begin
               state_in = ST_FINISH;
            end
         end

         // Issue one read per cycle, compare the previous one
         ST_FIND: begin
            if (total_ff == '0) begin
               res_status_in = gsp_pkg::STATUS_NOT_FOUND;
               state_in      = ST_FINISH;
            end else if (key_hit) begin
               res_slot_in   = gsp_pkg::INDEX_W'(prev_ff);
               res_gen_in    = gsp_pkg::GEN_W'(gen_rd);
               res_status_in = gsp_pkg::STATUS_OK;
               state_in      = ST_FINISH;
            end else if (scan_ff < span_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_idx;
               prev_in     = scan_idx;
               pend_in     = 1'b1;
               scan_in     = scan_ff + 1'b1;
            end else begin
               res_status_in = gsp_pkg::STATUS_NOT_FOUND;
               state_in      = ST_FINISH;
            end
         end

         // Hold the result until the output register takes it
         ST_FINISH: begin
            if (result_take) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= 1'b0;
         shrink_ff  <= 1'b0;
         append_ff  <= 1'b0;
         active_ff  <= '0;
         touched_ff <= '0;
         total_ff   <= '0;
         span_ff    <= '0;
         rev_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         pend_ff    <= pend_in;
         shrink_ff  <= shrink_in;
         append_ff  <= append_in;
         active_ff  <= active_in;
         touched_ff <= touched_in;
         total_ff   <= total_in;
         span_ff    <= span_in;
         rev_ff     <= rev_in;
      end
      cmd_ff        <= cmd_in;
      scan_ff       <= scan_in;
      pick_ff       <= pick_in;
      prev_ff       <= prev_in;
      res_slot_ff   <= res_slot_in;
      res_gen_ff    <= res_gen_in;
      res_status_ff <= res_status_in;
   end

   assign idle          = (state_ff == ST_IDLE);
   assign result_valid  = (state_ff == ST_FINISH);
   assign result.rev    = rev_ff;
   assign result.span   = gsp_pkg::COUNT_W'(span_ff);
   assign result.live   = gsp_pkg::COUNT_W'(total_ff);
   assign result.status = res_status_ff;
   assign result.gen    = res_gen_ff;
   assign result.slot   = res_slot_ff;

endmodule

// ===== design/generational_slot_pool.sv =====
// ----------------------------------------------------------------------------
// generational_slot_pool
// Pool of slots with active marks, keys and generation counts: reserve,
// release and find by key, one request at a time.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_     in         tuser: mode[1:0]; tdata: slot_index[3:0], lookup_key[19:4]
//  rsp_     out        tdata: chosen_slot, slot_generation, status, live_count,
//                      span_end, change_counter (low bits first)
//  csr_     in         write-only slot limit, taken on any cycle with csr_wr_en
//
//  Reserve scans the active marks from slot zero for the first hole below
//  the span end, else appends, then reads the chosen slot and writes its
//  bumped generation and key; a full pool answers after the scan. Find
//  reads and compares one slot per cycle up to the span end. Release checks
//  the slot, reads its generation and, if it ended the span, drops trailing
//  inactive slots. The next request is taken after the result is loaded.
//  Reset is synchronous; the pool is empty and usable on the next cycle.
//  A finished result waits in the output register, and the next request is
//  accepted meanwhile; the sequencer stalls only if that register is full.
// ----------------------------------------------------------------------------
module generational_slot_pool #(
   parameter int SLOT_COUNT      = gsp_pkg::SLOT_COUNT_DEF,
   parameter int KEY_BITS        = gsp_pkg::KEY_BITS_DEF,
   parameter int GENERATION_BITS = gsp_pkg::GEN_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [gsp_pkg::REQ_DATA_W-1:0]   req_tdata,  // slot_index, lookup_key
   input  logic [gsp_pkg::MODE_W-1:0]       req_tuser,  // mode
   // result
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // chosen_slot, slot_generation, status, live_count, span_end, change_counter
   output logic [gsp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [gsp_pkg::LIMIT_W-1:0]      csr_wr_data // slots_in_use_limit
);

   logic [gsp_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   gsp_pkg::result_type         rsp_data_ff, rsp_data_in;

   gsp_pkg::cmd_type            cmd;
   gsp_pkg::result_type         result;
   logic                        start;
   logic                        idle;
   logic                        result_valid;
   logic                        result_take;

   // Unpack the request
   assign cmd.mode  = req_tuser;
   assign cmd.index = req_tdata[gsp_pkg::INDEX_W-1:0];
   assign cmd.key   = req_tdata[gsp_pkg::INDEX_W +: gsp_pkg::KEY_W];

   assign req_tready = idle;
   assign start      = req_tvalid && req_tready;

   gsp_ctrl #(
      .SLOT_COUNT      (SLOT_COUNT),
      .KEY_BITS        (KEY_BITS),
      .GENERATION_BITS (GENERATION_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .cmd          (cmd),
      .limit        (limit_ff),
      .result_take  (result_take),
      .idle         (idle),
      .result_valid (result_valid),
      .result       (result)
   );

   // Load the output register when it is empty or being drained
   always_comb begin
      result_take  = result_valid && (!rsp_valid_ff || rsp_tready);
      rsp_valid_in = result_take || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = result_take ? result : rsp_data_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= gsp_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/gsp_checker.sv =====
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level checks on the slot pool: reset, output hold, failure results
// and one request in flight at a time.
// ----------------------------------------------------------------------------
module gsp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [gsp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   gsp_pkg::result_type rsp_view;

   assign rsp_view = rsp_tdata;

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Full pool and missed key report slot and generation zero
   a_fail_zero: assert property (@(posedge clock)
      rsp_tvalid && (rsp_view.status == gsp_pkg::STATUS_FULL ||
                     rsp_view.status == gsp_pkg::STATUS_NOT_FOUND)
      |-> rsp_view.slot == '0 && rsp_view.gen == '0)
      else $error("failed result carries a slot");

   // Not ready in the cycle after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind generational_slot_pool gsp_checker u_gsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
